>>> sv/hex_lattice_dimple_force_top_defines.svh
// Assertion macros for the hex lattice dimple force block.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef HEX_LATTICE_DIMPLE_FORCE_TOP_DEFINES_SVH
`define HEX_LATTICE_DIMPLE_FORCE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define HLDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define HLDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hldf_pkg.sv
// Shared constants for the hex lattice dimple force block.
// No dependencies; imported by the top level.
`default_nettype none

package hldf_pkg;

    // sqrt(3) in Q1.30
    localparam int SQRT3_W = 31;
    localparam logic [SQRT3_W-1:0] SQRT3_Q30 = 31'd1859775393;

    // fraction bits of the unit vector components
    localparam int UNIT_BITS = 28;

    // configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_SPACING   = 2'd0;
    localparam logic [1:0] REG_RADIUS    = 2'd1;
    localparam logic [1:0] REG_STIFFNESS = 2'd2;

endpackage

`default_nettype wire

>>> sv/hldf_div.sv
// Pipelined restoring divider: quotient and remainder, STEPS bits per stage.
// Carries a valid bit and a tag beside the data; no package dependency.
`default_nettype none

module hldf_div #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 33,
    parameter int QUOT_W = 32,
    parameter int STEPS  = 4,
    parameter int TAG_W  = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [TAG_W-1:0]  tag_in,
    output logic                   out_vld,
    output logic [QUOT_W-1:0]      quo,
    output logic [DEN_W-1:0]       rem,
    output logic [TAG_W-1:0]       tag_out
);

    localparam int REM_W = DEN_W + 1;
    localparam int NSTG  = (QUOT_W + STEPS - 1) / STEPS;

    logic              vld_reg [NSTG];
    logic [REM_W-1:0]  r_reg   [NSTG];
    logic [QUOT_W-1:0] lo_reg  [NSTG];
    logic [QUOT_W-1:0] q_reg   [NSTG];
    logic [DEN_W-1:0]  d_reg   [NSTG];
    logic [TAG_W-1:0]  tag_reg [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stage
            logic              v_in;
            logic [REM_W-1:0]  r_in;
            logic [QUOT_W-1:0] lo_in;
            logic [QUOT_W-1:0] q_in;
            logic [DEN_W-1:0]  d_in;
            logic [TAG_W-1:0]  t_in;
            logic [REM_W-1:0]  r_next;
            logic [QUOT_W-1:0] lo_next;
            logic [QUOT_W-1:0] q_next;
            logic [REM_W-1:0]  trial;

            // take the dividend high part as the first partial remainder
            if (s == 0)
            begin : g_first
                assign v_in  = in_vld;
                assign r_in  = REM_W'(num[NUM_W-1:QUOT_W]);
                assign lo_in = num[QUOT_W-1:0];
                assign q_in  = '0;
                assign d_in  = den;
                assign t_in  = tag_in;
            end
            else
            begin : g_rest
                assign v_in  = vld_reg[s-1];
                assign r_in  = r_reg[s-1];
                assign lo_in = lo_reg[s-1];
                assign q_in  = q_reg[s-1];
                assign d_in  = d_reg[s-1];
                assign t_in  = tag_reg[s-1];
            end

            // shift in one dividend bit per step, subtract where it fits
            always_comb
            begin
                r_next  = r_in;
                lo_next = lo_in;
                q_next  = q_in;
                trial   = '0;
                for (int j = 0; j < STEPS; j++)
                begin
                    if (s * STEPS + j < QUOT_W)
                    begin
                        trial   = {r_next[DEN_W-1:0], lo_next[QUOT_W-1]};
                        lo_next = {lo_next[QUOT_W-2:0], 1'b0};
                        if (trial >= {1'b0, d_in})
                        begin
                            r_next = trial - {1'b0, d_in};
                            q_next = {q_next[QUOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_next = trial;
                            q_next = {q_next[QUOT_W-2:0], 1'b0};
                        end
                    end
                end
            end

            // advance the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[s]   <= r_next;
                    lo_reg[s]  <= lo_next;
                    q_reg[s]   <= q_next;
                    d_reg[s]   <= d_in;
                    tag_reg[s] <= t_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[NSTG-1];
    assign quo     = q_reg[NSTG-1];
    assign rem     = r_reg[NSTG-1][DEN_W-1:0];
    assign tag_out = tag_reg[NSTG-1];

endmodule

`default_nettype wire

>>> sv/hldf_sqrt.sv
// Pipelined integer square root (floor), STEPS result bits per stage.
// Carries a valid bit and a tag beside the data; no package dependency.
`default_nettype none

module hldf_sqrt #(
    parameter int RES_W = 36,
    parameter int STEPS = 3,
    parameter int TAG_W = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [2*RES_W-1:0]   rad,
    input  wire logic [TAG_W-1:0]     tag_in,
    output logic                      out_vld,
    output logic [RES_W-1:0]          root,
    output logic [TAG_W-1:0]          tag_out
);

    localparam int RAD_W = 2 * RES_W;
    localparam int REM_W = RES_W + 2;
    localparam int NSTG  = (RES_W + STEPS - 1) / STEPS;

    logic             vld_reg  [NSTG];
    logic [REM_W-1:0] r_reg    [NSTG];
    logic [RAD_W-1:0] rad_reg  [NSTG];
    logic [RES_W-1:0] root_reg [NSTG];
    logic [TAG_W-1:0] tag_reg  [NSTG];

    genvar s;
    generate
        for (s = 0; s < NSTG; s++)
        begin : g_stage
            logic             v_in;
            logic [REM_W-1:0] r_in;
            logic [RAD_W-1:0] rad_in;
            logic [RES_W-1:0] root_in;
            logic [TAG_W-1:0] t_in;
            logic [REM_W-1:0] r_next;
            logic [RAD_W-1:0] rad_next;
            logic [RES_W-1:0] root_next;
            logic [REM_W+1:0] cand;
            logic [REM_W+1:0] trial;

            if (s == 0)
            begin : g_first
                assign v_in    = in_vld;
                assign r_in    = '0;
                assign rad_in  = rad;
                assign root_in = '0;
                assign t_in    = tag_in;
            end
            else
            begin : g_rest
                assign v_in    = vld_reg[s-1];
                assign r_in    = r_reg[s-1];
                assign rad_in  = rad_reg[s-1];
                assign root_in = root_reg[s-1];
                assign t_in    = tag_reg[s-1];
            end

            // bring down two radicand bits, try root*4+1
            always_comb
            begin
                r_next    = r_in;
                rad_next  = rad_in;
                root_next = root_in;
                cand      = '0;
                trial     = '0;
                for (int j = 0; j < STEPS; j++)
                begin
                    if (s * STEPS + j < RES_W)
                    begin
                        cand     = {r_next, rad_next[RAD_W-1:RAD_W-2]};
                        trial    = (REM_W+2)'({root_next, 2'b01});
                        rad_next = {rad_next[RAD_W-3:0], 2'b00};
                        if (cand >= trial)
                        begin
                            r_next    = REM_W'(cand - trial);
                            root_next = {root_next[RES_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_next    = REM_W'(cand);
                            root_next = {root_next[RES_W-2:0], 1'b0};
                        end
                    end
                end
            end

            // advance the stage
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[s]    <= r_next;
                    rad_reg[s]  <= rad_next;
                    root_reg[s] <= root_next;
                    tag_reg[s]  <= t_in;
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[NSTG-1];
    assign root    = root_reg[NSTG-1];
    assign tag_out = tag_reg[NSTG-1];

endmodule

`default_nettype wire

>>> sv/hex_lattice_dimple_force_top.sv
// Hex lattice dimple force: nearest-dimple elastic force on one particle.
// Depends on hldf_pkg, hldf_div, hldf_sqrt and the assertion macro header.
//
// Usage:
//   Slave stream s_*: one particle per item (position, radius in tdata, free flag
//   in tuser). Master stream m_*: one force item per particle, in order.
//   APB port: dimple spacing (0x0), dimple radius (0x4), stiffness (0x8);
//   write only while no item is in flight.
// Stages: 2 input stages, 8 for the cell fold divider, 3 for site selection,
//   12 for the square root, 1 for the force magnitude, 8 for the unit vector
//   divider, 2 for the final products and saturation.
// Throughput: one item per cycle unless stalled; every unit is fully pipelined.
// Stall: the whole pipeline holds while the output register carries an item
//   that is not taken; s_tready = !m_tvalid || m_tready.
// Reset: all valid bits clear, registers return to spacing 1.0, radius 0,
//   stiffness 1.0; no clearing pass is needed.
`default_nettype none
`include "hex_lattice_dimple_force_top_defines.svh"

module hex_lattice_dimple_force_top
    import hldf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // particle items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] radius
    input  wire logic         s_tuser,   // [0] is_free
    // force items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // [31:0] force_x, [63:32] force_y
    output logic              m_tuser,   // [0] applied
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DIV_STEPS  = 4;
    localparam int SQRT_STEPS = 3;
    localparam int OFS_W      = 36;
    localparam int MAG_OFS_W  = 34;
    localparam int SQ_W       = 2 * MAG_OFS_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int DIST_W     = 36;
    localparam int PROD_W     = 32 + DIST_W;
    localparam int FN_W       = PROD_W - (FRAC_BITS + 1);
    localparam int UQ_W       = UNIT_BITS + 1;
    localparam int LO_W       = FN_W / 2;
    localparam int HI_W       = FN_W - LO_W;
    localparam int P_W        = FN_W + UQ_W;
    localparam int MAG_W      = P_W - UNIT_BITS;
    localparam int UNUM_W     = MAG_OFS_W + UNIT_BITS;

    typedef logic signed [OFS_W-1:0] ofs_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] px;
        logic [31:0] py;
        logic [33:0] reach;
        logic [31:0] k;
        logic [31:0] sp;
        logic [62:0] prod;
    } s1_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] px;
        logic [31:0] py;
        logic [33:0] reach;
        logic [31:0] k;
        logic [32:0] dlx;
        logic [31:0] dly;
    } s2_t;

    typedef struct packed {
        logic        ok;
        logic [33:0] reach;
        logic [31:0] k;
        logic [32:0] dlx;
    } xtag_t;

    typedef struct packed {
        logic        ok;
        logic [33:0] reach;
        logic [31:0] k;
        ofs_t        cx;
        ofs_t        cy;
        ofs_t        mx;
        ofs_t        my;
        ofs_t        ax;
    } s3_t;

    typedef struct packed {
        logic            ok;
        logic [33:0]     reach;
        logic [31:0]     k;
        ofs_t            cx;
        ofs_t            cy;
        ofs_t            mx;
        ofs_t            my;
        logic [SQ_W-1:0] sq_cx;
        logic [SQ_W-1:0] sq_cy;
        logic [SQ_W-1:0] sq_mx;
        logic [SQ_W-1:0] sq_my;
        logic [SQ_W-1:0] sq_ax;
    } s4_t;

    typedef struct packed {
        logic            ok;
        logic [33:0]     reach;
        logic [31:0]     k;
        ofs_t            ox;
        ofs_t            oy;
        logic [D2_W-1:0] d2;
    } s5_t;

    typedef struct packed {
        logic        ok;
        logic [33:0] reach;
        logic [31:0] k;
        ofs_t        ox;
        ofs_t        oy;
    } qtag_t;

    typedef struct packed {
        logic              ok;
        logic              xneg;
        ofs_t              ox;
        ofs_t              oy;
        logic [DIST_W-1:0] site_dist;
        logic [PROD_W-1:0] prod;
    } s6_t;

    typedef struct packed {
        logic            ok;
        logic            negx;
        logic [FN_W-1:0] fn;
    } utag_t;

    typedef struct packed {
        logic                 ok;
        logic                 negx;
        logic                 negy;
        logic [LO_W+UQ_W-1:0] plx;
        logic [HI_W+UQ_W-1:0] phx;
        logic [LO_W+UQ_W-1:0] ply;
        logic [HI_W+UQ_W-1:0] phy;
    } s7_t;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        applied;
    } out_t;

    function automatic logic [MAG_OFS_W-1:0] mag_ofs(input ofs_t v);
        logic [OFS_W-1:0] a;
        a = v[OFS_W-1] ? OFS_W'(-v) : OFS_W'(v);
        return a[MAG_OFS_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sq_ofs(input ofs_t v);
        logic [MAG_OFS_W-1:0] m;
        m = mag_ofs(v);
        return SQ_W'(m) * SQ_W'(m);
    endfunction

    // clamp a magnitude to the signed 32-bit range and apply the sign
    function automatic logic [31:0] sat_comp(input logic [MAG_W-1:0] m, input logic neg);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] sm;
        lim = neg ? MAG_W'(33'h0_8000_0000) : MAG_W'(33'h0_7FFF_FFFF);
        sm  = (m > lim) ? lim : m;
        return neg ? (32'd0 - sm[31:0]) : sm[31:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [31:0] spacing_reg;
    logic [31:0] radius_reg;
    logic [31:0] stiffness_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // write the addressed register at the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= 32'd65536;
            radius_reg    <= 32'd0;
            stiffness_reg <= 32'd65536;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_SPACING:   spacing_reg   <= pwdata;
                REG_RADIUS:    radius_reg    <= pwdata;
                REG_STIFFNESS: stiffness_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_SPACING:   prdata = spacing_reg;
            REG_RADIUS:    prdata = radius_reg;
            REG_STIFFNESS: prdata = stiffness_reg;
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: everything moves unless the output item is held
    // ------------------------------------------------------------------
    logic adv;
    logic out_vld_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // stage 1: capture item and config, start the cell width product
    // ------------------------------------------------------------------
    s1_t  s1_next;
    s1_t  s1_reg;
    logic v1_reg;

    always_comb
    begin
        s1_next.ok    = s_tuser && (spacing_reg != 32'd0);
        s1_next.px    = s_tdata[31:0];
        s1_next.py    = s_tdata[63:32];
        s1_next.reach = {33'(s_tdata[95:64]) + 33'(radius_reg), 1'b0};
        s1_next.k     = stiffness_reg;
        s1_next.sp    = spacing_reg;
        s1_next.prod  = 63'(spacing_reg) * 63'(SQRT3_Q30);
    end

    // ------------------------------------------------------------------
    // stage 2: round the cell width
    // ------------------------------------------------------------------
    s2_t         s2_next;
    s2_t         s2_reg;
    logic        v2_reg;
    logic [63:0] wround;

    always_comb
    begin
        wround        = 64'(s1_reg.prod) + 64'(33'h0_2000_0000);
        s2_next.ok    = s1_reg.ok;
        s2_next.px    = s1_reg.px;
        s2_next.py    = s1_reg.py;
        s2_next.reach = s1_reg.reach;
        s2_next.k     = s1_reg.k;
        s2_next.dlx   = wround[62:30];
        s2_next.dly   = s1_reg.sp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // fold the position into one cell
    // ------------------------------------------------------------------
    xtag_t       xtag_in;
    xtag_t       xtag_out;
    logic        vfx;
    logic        vfy;
    logic [31:0] fqx;
    logic [31:0] fqy;
    logic [32:0] rx;
    logic [31:0] ry;
    logic [31:0] dly_out;

    assign xtag_in.ok    = s2_reg.ok;
    assign xtag_in.reach = s2_reg.reach;
    assign xtag_in.k     = s2_reg.k;
    assign xtag_in.dlx   = s2_reg.dlx;

    hldf_div #(
        .NUM_W  (33),
        .DEN_W  (33),
        .QUOT_W (32),
        .STEPS  (DIV_STEPS),
        .TAG_W  ($bits(xtag_t))
    ) u_fold_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v2_reg),
        .num     ({1'b0, s2_reg.px}),
        .den     (s2_reg.dlx),
        .tag_in  (xtag_in),
        .out_vld (vfx),
        .quo     (fqx),
        .rem     (rx),
        .tag_out (xtag_out)
    );

    hldf_div #(
        .NUM_W  (33),
        .DEN_W  (32),
        .QUOT_W (32),
        .STEPS  (DIV_STEPS),
        .TAG_W  (32)
    ) u_fold_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v2_reg),
        .num     ({1'b0, s2_reg.py}),
        .den     (s2_reg.dly),
        .tag_in  (s2_reg.dly),
        .out_vld (vfy),
        .quo     (fqy),
        .rem     (ry),
        .tag_out (dly_out)
    );

    // ------------------------------------------------------------------
    // stage 3: quadrant and candidate offsets (doubled units)
    // ------------------------------------------------------------------
    s3_t  s3_next;
    s3_t  s3_reg;
    logic v3_reg;
    ofs_t xs;
    ofs_t ys;
    ofs_t ws;
    ofs_t hs;
    ofs_t hws;
    ofs_t hhs;
    logic left;
    logic low;

    always_comb
    begin
        xs   = signed'(OFS_W'({rx, 1'b0}));
        ys   = signed'(OFS_W'({ry, 1'b0}));
        hws  = signed'(OFS_W'(xtag_out.dlx));
        hhs  = signed'(OFS_W'(dly_out));
        ws   = signed'(OFS_W'({xtag_out.dlx, 1'b0}));
        hs   = signed'(OFS_W'({dly_out, 1'b0}));
        left = xs < hws;
        low  = ys < hhs;
        s3_next.ok    = xtag_out.ok;
        s3_next.reach = xtag_out.reach;
        s3_next.k     = xtag_out.k;
        s3_next.cx    = left ? (ofs_t'(0) - xs) : (ws - xs);
        s3_next.cy    = low ? (ofs_t'(0) - ys) : (hs - ys);
        s3_next.mx    = hws - xs;
        s3_next.my    = hhs - ys;
        // upper-left quadrant compares against the full-width term
        s3_next.ax    = (left && !low) ? (ws - xs) : (hws - xs);
    end

    // ------------------------------------------------------------------
    // stage 4: squares of all candidate terms
    // ------------------------------------------------------------------
    s4_t  s4_next;
    s4_t  s4_reg;
    logic v4_reg;

    always_comb
    begin
        s4_next.ok    = s3_reg.ok;
        s4_next.reach = s3_reg.reach;
        s4_next.k     = s3_reg.k;
        s4_next.cx    = s3_reg.cx;
        s4_next.cy    = s3_reg.cy;
        s4_next.mx    = s3_reg.mx;
        s4_next.my    = s3_reg.my;
        s4_next.sq_cx = sq_ofs(s3_reg.cx);
        s4_next.sq_cy = sq_ofs(s3_reg.cy);
        s4_next.sq_mx = sq_ofs(s3_reg.mx);
        s4_next.sq_my = sq_ofs(s3_reg.my);
        s4_next.sq_ax = sq_ofs(s3_reg.ax);
    end

    // ------------------------------------------------------------------
    // stage 5: pick the nearer site, window and zero-distance tests
    // ------------------------------------------------------------------
    s5_t             s5_next;
    s5_t             s5_reg;
    logic            v5_reg;
    logic [D2_W-1:0] d2_corner;
    logic [D2_W-1:0] d2_alt;
    logic [D2_W-1:0] d2_center;
    logic            pick;
    logic            win;

    always_comb
    begin
        d2_corner = D2_W'(s4_reg.sq_cx) + D2_W'(s4_reg.sq_cy);
        d2_alt    = D2_W'(s4_reg.sq_ax) + D2_W'(s4_reg.sq_my);
        d2_center = D2_W'(s4_reg.sq_mx) + D2_W'(s4_reg.sq_my);
        pick      = d2_corner < d2_alt;
        s5_next.ox    = pick ? s4_reg.cx : s4_reg.mx;
        s5_next.oy    = pick ? s4_reg.cy : s4_reg.my;
        s5_next.d2    = pick ? d2_corner : d2_center;
        s5_next.reach = s4_reg.reach;
        s5_next.k     = s4_reg.k;
        win = (mag_ofs(s5_next.ox) < s4_reg.reach) && (mag_ofs(s5_next.oy) < s4_reg.reach);
        s5_next.ok    = s4_reg.ok && win && (s5_next.d2 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= vfx && vfy;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
        end
    end

    // ------------------------------------------------------------------
    // distance
    // ------------------------------------------------------------------
    qtag_t             qtag_in;
    qtag_t             qtag_out;
    logic              vq;
    logic [DIST_W-1:0] site_dist;

    assign qtag_in.ok    = s5_reg.ok;
    assign qtag_in.reach = s5_reg.reach;
    assign qtag_in.k     = s5_reg.k;
    assign qtag_in.ox    = s5_reg.ox;
    assign qtag_in.oy    = s5_reg.oy;

    hldf_sqrt #(
        .RES_W (DIST_W),
        .STEPS (SQRT_STEPS),
        .TAG_W ($bits(qtag_t))
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v5_reg),
        .rad     ((2*DIST_W)'(s5_reg.d2)),
        .tag_in  (qtag_in),
        .out_vld (vq),
        .root    (site_dist),
        .tag_out (qtag_out)
    );

    // ------------------------------------------------------------------
    // stage 6: compression and force magnitude product
    // ------------------------------------------------------------------
    s6_t                s6_next;
    s6_t                s6_reg;
    logic               v6_reg;
    logic signed [36:0] xi;
    logic [DIST_W-1:0]  xi_mag;

    always_comb
    begin
        xi     = signed'(37'(qtag_out.reach)) - signed'(37'(site_dist));
        xi_mag = xi[36] ? DIST_W'(-xi) : DIST_W'(xi);
        s6_next.ok        = qtag_out.ok;
        s6_next.xneg      = xi[36];
        s6_next.ox        = qtag_out.ox;
        s6_next.oy        = qtag_out.oy;
        s6_next.site_dist = site_dist;
        s6_next.prod      = PROD_W'(qtag_out.k) * PROD_W'(xi_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg <= vq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_reg <= s6_next;
        end
    end

    // ------------------------------------------------------------------
    // unit vector components
    // ------------------------------------------------------------------
    utag_t             utag_in;
    utag_t             utag_out;
    logic              vux;
    logic              vuy;
    logic              negy_out;
    logic [UQ_W-1:0]   ex;
    logic [UQ_W-1:0]   ey;
    logic [DIST_W-1:0] urx;
    logic [DIST_W-1:0] ury;

    assign utag_in.ok   = s6_reg.ok;
    assign utag_in.negx = s6_reg.xneg ^ s6_reg.ox[OFS_W-1];
    assign utag_in.fn   = s6_reg.prod[PROD_W-1:FRAC_BITS+1];

    hldf_div #(
        .NUM_W  (UNUM_W),
        .DEN_W  (DIST_W),
        .QUOT_W (UQ_W),
        .STEPS  (DIV_STEPS),
        .TAG_W  ($bits(utag_t))
    ) u_unit_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v6_reg),
        .num     ({mag_ofs(s6_reg.ox), UNIT_BITS'(0)}),
        .den     (s6_reg.site_dist),
        .tag_in  (utag_in),
        .out_vld (vux),
        .quo     (ex),
        .rem     (urx),
        .tag_out (utag_out)
    );

    hldf_div #(
        .NUM_W  (UNUM_W),
        .DEN_W  (DIST_W),
        .QUOT_W (UQ_W),
        .STEPS  (DIV_STEPS),
        .TAG_W  (1)
    ) u_unit_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (v6_reg),
        .num     ({mag_ofs(s6_reg.oy), UNIT_BITS'(0)}),
        .den     (s6_reg.site_dist),
        .tag_in  (s6_reg.xneg ^ s6_reg.oy[OFS_W-1]),
        .out_vld (vuy),
        .quo     (ey),
        .rem     (ury),
        .tag_out (negy_out)
    );

    // ------------------------------------------------------------------
    // stage 7: split products magnitude * unit component
    // ------------------------------------------------------------------
    s7_t  s7_next;
    s7_t  s7_reg;
    logic v7_reg;

    always_comb
    begin
        s7_next.ok   = utag_out.ok;
        s7_next.negx = utag_out.negx;
        s7_next.negy = negy_out;
        s7_next.plx  = (LO_W+UQ_W)'(utag_out.fn[LO_W-1:0]) * (LO_W+UQ_W)'(ex);
        s7_next.phx  = (HI_W+UQ_W)'(utag_out.fn[FN_W-1:LO_W]) * (HI_W+UQ_W)'(ex);
        s7_next.ply  = (LO_W+UQ_W)'(utag_out.fn[LO_W-1:0]) * (LO_W+UQ_W)'(ey);
        s7_next.phy  = (HI_W+UQ_W)'(utag_out.fn[FN_W-1:LO_W]) * (HI_W+UQ_W)'(ey);
    end

    // ------------------------------------------------------------------
    // output stage: combine, saturate, mask
    // ------------------------------------------------------------------
    out_t           out_next;
    out_t           out_reg;
    logic [P_W-1:0] sum_x;
    logic [P_W-1:0] sum_y;
    logic [31:0]    cfx;
    logic [31:0]    cfy;

    always_comb
    begin
        sum_x = {s7_reg.phx, LO_W'(0)} + P_W'(s7_reg.plx);
        sum_y = {s7_reg.phy, LO_W'(0)} + P_W'(s7_reg.ply);
        cfx   = sat_comp(sum_x[P_W-1:UNIT_BITS], s7_reg.negx);
        cfy   = sat_comp(sum_y[P_W-1:UNIT_BITS], s7_reg.negy);
        out_next.fx      = s7_reg.ok ? cfx : 32'd0;
        out_next.fy      = s7_reg.ok ? cfy : 32'd0;
        out_next.applied = s7_reg.ok && ((cfx != 32'd0) || (cfy != 32'd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg      <= vux && vuy;
            out_vld_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_reg  <= s7_next;
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_reg.fy, out_reg.fx};
    assign m_tuser  = out_reg.applied;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `HLDF_ASSERT_NOW(a_applied_nonzero, m_tvalid && m_tuser, m_tdata != 64'd0,
        "applied flag set on a zero force")
    `HLDF_ASSERT_NOW(a_idle_zero, m_tvalid && !m_tuser, m_tdata == 64'd0,
        "force present without applied flag")
    `HLDF_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
        "input taken while output item is held")
    `HLDF_ASSERT_NEXT(a_stall_holds_pipe, v7_reg && out_vld_reg && !m_tready,
        v7_reg && out_vld_reg, "pipeline item lost during stall")

endmodule

`default_nettype wire

>>> verif/hex_lattice_dimple_force_checker.sv
// Checker for the hex lattice dimple force block: snoops the register port,
// predicts each force item and compares it with the master stream. Uses hldf_pkg.
`timescale 1ns / 100ps

module hex_lattice_dimple_force_checker
    import hldf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] radius
    input  logic         s_tuser,   // [0] is_free
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,   // [31:0] force_x, [63:32] force_y
    input  logic         m_tuser,   // [0] applied
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending,
    output int           forces_seen
);

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic        applied;
    } force_t;

    logic [31:0] spacing_q;
    logic [31:0] dimple_r_q;
    logic [31:0] stiffness_q;
    force_t      force_queue[$];

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [127:0] norm2(longint a, longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = abs64(a);
        mb = abs64(b);
        return 128'(ma) * 128'(ma) + 128'(mb) * 128'(mb);
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int i = 40; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (!(n < 128'(trial) * 128'(trial)))
                root = trial;
        end
        return root;
    endfunction

    // Scale magnitude fn by the unit component of o, then saturate
    function automatic logic [31:0] force_comp(logic [63:0] fn, logic xi_neg, longint o,
                                               logic [63:0] d);
        logic [63:0]  e;
        logic [127:0] p;
        logic         neg;
        logic [63:0]  lim;
        logic [31:0]  m;
        e   = (abs64(o) << UNIT_BITS) / d;
        p   = (128'(fn) * 128'(e)) >> UNIT_BITS;
        neg = xi_neg != (o < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        m   = (p > 128'(lim)) ? lim[31:0] : p[31:0];
        return neg ? (~m + 32'd1) : m;
    endfunction

    function automatic force_t predict_force(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pr, logic free);
        force_t      res;
        logic [63:0] dlx;
        longint      w, h, hw, hh, xx, yy, ox, oy, reach, xi;
        logic [63:0] site_dist;
        logic [63:0] fn;
        logic [127:0] d2;
        res = '0;
        if (spacing_q == 0 || !free)
            return res;
        dlx   = (64'(spacing_q) * 64'(SQRT3_Q30) + (64'd1 << 29)) >> 30;
        hw    = longint'(dlx);
        hh    = longint'(64'(spacing_q));
        w     = 2 * hw;
        h     = 2 * hh;
        xx    = longint'((64'(px) % dlx) << 1);
        yy    = longint'((64'(py) % 64'(spacing_q)) << 1);
        reach = longint'((64'(pr) + 64'(dimple_r_q)) << 1);
        // Pick the nearer of corner site and centre site, per quadrant
        ox = hw - xx;
        oy = hh - yy;
        if (xx < hw)
        begin
            if (yy < hh)
            begin
                if (norm2(xx, yy) < norm2(hw - xx, hh - yy))
                begin
                    ox = -xx;
                    oy = -yy;
                end
            end
            else if (norm2(xx, h - yy) < norm2(w - xx, yy - hh))
            begin
                ox = -xx;
                oy = h - yy;
            end
        end
        else
        begin
            if (yy < hh)
            begin
                if (norm2(w - xx, yy) < norm2(hw - xx, hh - yy))
                begin
                    ox = w - xx;
                    oy = -yy;
                end
            end
            else if (norm2(w - xx, h - yy) < norm2(hw - xx, yy - hh))
            begin
                ox = w - xx;
                oy = h - yy;
            end
        end
        if (!(longint'(abs64(ox)) < reach && longint'(abs64(oy)) < reach))
            return res;
        d2 = norm2(ox, oy);
        if (d2 == 0)
            return res;
        site_dist = isqrt(d2);
        xi   = reach - longint'(site_dist);
        fn   = 64'((128'(stiffness_q) * 128'(abs64(xi))) >> 17);
        res.fx = force_comp(fn, xi < 0, ox, site_dist);
        res.fy = force_comp(fn, xi < 0, oy, site_dist);
        res.applied = (res.fx != 0) || (res.fy != 0);
        return res;
    endfunction

    assign pending = force_queue.size();

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        force_t want;
        if (!rst_n)
        begin
            spacing_q   <= 32'h0001_0000;
            dimple_r_q  <= 32'h0;
            stiffness_q <= 32'h0001_0000;
            fail_count  <= 0;
            forces_seen <= 0;
            force_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_SPACING:   spacing_q   <= pwdata;
                    REG_RADIUS:    dimple_r_q  <= pwdata;
                    REG_STIFFNESS: stiffness_q <= pwdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                forces_seen <= forces_seen + 1;
                if (force_queue.size() == 0)
                begin
                    $error("force item with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = force_queue.pop_front();
                    if (m_tdata[31:0] !== want.fx)
                        $error("force_x expected %h actual %h", want.fx, m_tdata[31:0]);
                    if (m_tdata[63:32] !== want.fy)
                        $error("force_y expected %h actual %h", want.fy, m_tdata[63:32]);
                    if (m_tuser !== want.applied)
                        $error("applied expected %b actual %b", want.applied, m_tuser);
                    if (m_tdata[31:0] !== want.fx || m_tdata[63:32] !== want.fy
                        || m_tuser !== want.applied)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_tvalid && s_tready)
                force_queue.insert(force_queue.size(),
                                   predict_force(s_tdata[31:0], s_tdata[63:32],
                                                 s_tdata[95:64], s_tuser));
        end
    end

endmodule

>>> verif/hex_lattice_dimple_force_top_test.sv
// Testbench top for the hex lattice dimple force block: clock, reset, register
// phases and particle stimulus. Depends on hldf_pkg and the force checker.
`timescale 1ns / 100ps

module hex_lattice_dimple_force_top_test
    import hldf_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 7;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;   // [31:0] pos_x, [63:32] pos_y, [95:64] radius
    logic        s_tuser = 0;    // [0] is_free
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;        // [31:0] force_x, [63:32] force_y
    logic        m_tuser;        // [0] applied
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          forces_seen;
    int          cycle_count = 0;
    int          items_sent = 0;
    logic [31:0] cur_spacing = 32'h0001_0000;
    logic        hold_off = 0;

    always #6 clk = ~clk;

    hex_lattice_dimple_force_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hex_lattice_dimple_force_checker force_check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending), .forces_seen(forces_seen)
    );

    // Idle rarely, never inside the quiet window
    function automatic logic want_idle();
        if (cycle_count > 950 && cycle_count < 1250)
            return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    // Hold the receiver off for a long stretch in the middle of a phase
    initial
    begin
        wait (items_sent >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Receiver: sparse stalls, off entirely during the hold-off
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= !want_idle();
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pr,
                                 logic free);
        while (want_idle())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pr, py, px};
        s_tuser  <= free;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_SPACING)
            cur_spacing = value;
    endtask

    // Drain the pipeline before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [31:0] pr;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0: pr = $urandom;
                1: pr = 0;
                default: pr = $urandom_range(0, cur_spacing);
            endcase
            send_particle($urandom, $urandom, pr, $urandom_range(9) != 0);
        end
    endtask

    logic [31:0] phase_spacing [PHASES] = '{32'h0000_8000, 32'hFFFF_FFFF, 32'h0,
                                           32'h1, 32'h0002_A000, 32'h0001_0000, 32'h0003_0000};
    logic [31:0] phase_radius [PHASES] = '{32'h0000_4000, 32'hFFFF_FFFF, 32'h0001_0000,
                                          32'h0, 32'h0000_8000, 32'h0000_2000, 32'h0};
    logic [31:0] phase_stiff [PHASES] = '{32'h0003_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                                         32'hFFFF_FFFF, 32'h0, 32'h0018_0000, 32'h0000_0100};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings (spacing 1.0)
        send_particle(32'h0, 32'h0, 32'h0000_8000, 1'b1);
        send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_particle(32'd56756, 32'h0000_8000, 32'h0001_0000, 1'b1);   // on centre site
        send_particle(32'h0000_1000, 32'h0000_C000, 32'h0001_0000, 1'b1); // upper left
        send_particle(32'h0000_2000, 32'h0000_2000, 32'h0001_0000, 1'b1); // lower left
        send_particle(32'h0001_8000, 32'h0000_1000, 32'h0001_0000, 1'b1); // lower right
        send_particle(32'h0001_8000, 32'h0000_F000, 32'h0001_0000, 1'b1); // upper right
        send_particle(32'h0000_2000, 32'h0000_2000, 32'h0, 1'b1);         // outside window
        send_particle(32'd113512, 32'h0001_0000, 32'h0000_4000, 1'b1);    // on corner site
        send_particle(32'h0000_0100, 32'h0000_0100, 32'h0, 1'b1);
        send_random(100);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_SPACING, phase_spacing[p]);
            write_reg(REG_RADIUS, phase_radius[p]);
            write_reg(REG_STIFFNESS, phase_stiff[p]);
            send_random(78);
            drain();
        end

        repeat (40) @(posedge clk);
        $display("covered %0d particles, %0d forces checked, over %0d register settings",
                 items_sent, forces_seen, PHASES + 1);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
